// ===== hdl/snt_pkg.sv =====
// shared constants, types and note frequency table for the note tracker
package snt_pkg;

    localparam int NOTE_COUNT    = 96;
    localparam int CHANNEL_COUNT = 3;
    localparam int TABLE_LEN     = 96;
    localparam int NOTE_W        = 7;
    localparam int CNT_W         = $clog2(NOTE_COUNT + 1);
    localparam int CH_W          = 2;
    localparam int FREQ_W        = 16;
    localparam int WAVE_W        = 8;
    localparam int FACTOR_W      = 8;
    localparam int DIST_W        = FREQ_W + 1;
    localparam int DIV_STEPS     = FREQ_W;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS);
    localparam int GATE_BIT      = 0;

    localparam logic [WAVE_W-1:0]   SOUNDING_MIN = 8'h10;
    localparam logic [DIST_W-1:0]   DIST_START   = 17'h10000;
    localparam logic [FREQ_W-1:0]   FREQ_BEYOND  = 16'hFFFF;

    // per-channel state kept in the channel memory
    typedef struct packed {
        logic [NOTE_W-1:0] note;
        logic [FREQ_W-1:0] freq;
        logic [WAVE_W-1:0] wave;
    } chan_state_t;

    typedef struct packed {
        logic                start;
        logic [FREQ_W-1:0]   dividend;
        logic [FACTOR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [FREQ_W-1:0] quotient;
    } div_rsp_t;

    localparam logic [FREQ_W-1:0] NOTE_FREQ [TABLE_LEN] = '{
        16'h0117, 16'h0127, 16'h0139, 16'h014b, 16'h015f, 16'h0174,
        16'h018a, 16'h01a1, 16'h01ba, 16'h01d4, 16'h01f0, 16'h020e,
        16'h022d, 16'h024e, 16'h0271, 16'h0296, 16'h02be, 16'h02e8,
        16'h0314, 16'h0343, 16'h0374, 16'h03a9, 16'h03e1, 16'h041c,
        16'h045a, 16'h049c, 16'h04e2, 16'h052d, 16'h057c, 16'h05cf,
        16'h0628, 16'h0685, 16'h06e8, 16'h0752, 16'h07c1, 16'h0837,
        16'h08b4, 16'h0939, 16'h09c5, 16'h0a5a, 16'h0af7, 16'h0b9e,
        16'h0c4f, 16'h0d0a, 16'h0dd1, 16'h0ea3, 16'h0f82, 16'h106e,
        16'h1168, 16'h1271, 16'h138a, 16'h14b3, 16'h15ee, 16'h173c,
        16'h189e, 16'h1a15, 16'h1ba2, 16'h1d46, 16'h1f04, 16'h20dc,
        16'h22d0, 16'h24e2, 16'h2714, 16'h2967, 16'h2bdd, 16'h2e79,
        16'h313c, 16'h3429, 16'h3744, 16'h3a8d, 16'h3e08, 16'h41b8,
        16'h45a1, 16'h49c5, 16'h4e28, 16'h52cd, 16'h57ba, 16'h5cf1,
        16'h6278, 16'h6853, 16'h6e87, 16'h751a, 16'h7c10, 16'h8371,
        16'h8b42, 16'h9389, 16'h9c4f, 16'ha59b, 16'haf74, 16'hb9e2,
        16'hc4f0, 16'hd0a6, 16'hdd0e, 16'hea33, 16'hf820, 16'hffff
    };

    // entries past the end of the table read as the top frequency
    function automatic logic [FREQ_W-1:0] note_freq(input logic [NOTE_W-1:0] idx);
        logic [FREQ_W-1:0] val;
        val = FREQ_BEYOND;
        if (int'(idx) < TABLE_LEN)
        begin
            val = NOTE_FREQ[idx];
        end
        return val;
    endfunction

endpackage

// ===== hdl/snt_state_ram.sv =====
// per-channel state memory, registered read, valid bits for reset
module snt_state_ram
    import snt_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            rd_en,
    input  logic [CH_W-1:0] rd_addr,
    output chan_state_t     rd_data,
    input  logic            wr_en,
    input  logic [CH_W-1:0] wr_addr,
    input  chan_state_t     wr_data
);

    chan_state_t mem_reg [CHANNEL_COUNT];
    logic [CHANNEL_COUNT-1:0] valid_reg;
    chan_state_t rd_data_reg;
    logic        rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // never-written entries read as the reset value
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== hdl/snt_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module snt_div
    import snt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [FACTOR_W:0]    rem_reg;
    logic [FREQ_W-1:0]    quo_reg;
    logic [FACTOR_W-1:0]  div_reg;

    logic [FACTOR_W:0] rem_sh;
    logic              ge;

    assign rem_sh = {rem_reg[FACTOR_W-1:0], quo_reg[FREQ_W-1]};
    assign ge     = rem_sh >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            div_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (rem_sh - {1'b0, div_reg}) : rem_sh;
            quo_reg <= {quo_reg[FREQ_W-2:0], ge};
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== hdl/sticky_nearest_note_tracker_top.sv =====
// sticky nearest-note tracker: per-channel state memory, table scan and divider
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------------------
//  in      | to block  | in_valid/in_stall  | channel, osc_freq, wave_ctrl, first_frame
//  out     | from block| out_valid/out_stall| out_channel, note, note_changed, retrigger,
//          |           |                    | freq_delta, searched
//  cfg     | to block  | cfg_wr_en          | cfg_wr_data (old_note_factor)
//
// no search: the item passes S_EVAL and S_FIN into the result register, then S_IDLE takes the next
// search: one table entry a cycle in S_SCAN, the walk paused in S_DIV while the bit-serial
// divider divides the distance when the previous note wins during the walk
// one item in work at a time; a finished item waits while a result is stalled in the
// output register, and the next transfer comes the cycle after it is stored
// reset clears control state, channel memory valid bits and sets the factor to 1
module sticky_nearest_note_tracker_top
    import snt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration
    input  logic                     cfg_wr_en,
    input  logic [FACTOR_W-1:0]      cfg_wr_data,
    // input channel
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [CH_W-1:0]          channel,
    input  logic [FREQ_W-1:0]        osc_freq,
    input  logic [WAVE_W-1:0]        wave_ctrl,
    input  logic                     first_frame,
    // output channel
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [CH_W-1:0]          out_channel,
    output logic [NOTE_W-1:0]        note,
    output logic                     note_changed,
    output logic                     retrigger,
    output logic signed [DIST_W-1:0] freq_delta,
    output logic                     searched
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EVAL = 5'b00010,
        S_SCAN = 5'b00100,
        S_DIV  = 5'b01000,
        S_FIN  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // latched input transfer
    logic [CH_W-1:0]     ch_reg;
    logic [FREQ_W-1:0]   freq_reg;
    logic [WAVE_W-1:0]   wave_reg;
    logic                first_reg;
    logic                in_range_reg;

    // working values of the current item
    logic [NOTE_W-1:0]   note_reg;
    logic [NOTE_W-1:0]   old_note_reg;
    logic                has_old_reg;
    logic                retrig_reg;
    logic                search_reg;
    logic [DIST_W-1:0]   delta_reg;
    logic [DIST_W-1:0]   dist_reg;
    logic [CNT_W-1:0]    cnt_reg;

    logic [FACTOR_W-1:0] factor_reg;

    // result register
    logic                out_valid_reg;
    logic [CH_W-1:0]     out_channel_reg;
    logic [NOTE_W-1:0]   out_note_reg;
    logic                out_changed_reg;
    logic                out_retrig_reg;
    logic [DIST_W-1:0]   out_delta_reg;
    logic                out_search_reg;

    chan_state_t prev_state;
    chan_state_t wr_state;
    div_req_t    div_req;
    div_rsp_t    div_rsp;

    logic                in_xfer;
    logic                out_free;
    logic                ram_wr_en;
    logic                sounding;
    logic                retrig_c;
    logic                search_c;
    logic [DIST_W-1:0]   delta_c;
    logic [NOTE_W-1:0]   idx;
    logic [FREQ_W-1:0]   cmp_freq;
    logic [FREQ_W-1:0]   diff;
    logic                win;
    logic                hit_old;
    logic [CNT_W-1:0]    cnt_inc;
    logic                scan_end;
    logic [FACTOR_W-1:0] factor_eff;

    // handshakes: busy from transfer until the result is stored
    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // channel memory: read on transfer, written back when the result is stored
    assign ram_wr_en = (state_reg == S_FIN) && out_free && in_range_reg;
    assign wr_state  = '{note: note_reg, freq: freq_reg, wave: wave_reg};

    snt_state_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_xfer && (int'(channel) < CHANNEL_COUNT)),
        .rd_addr (channel),
        .rd_data (prev_state),
        .wr_en   (ram_wr_en),
        .wr_addr (ch_reg),
        .wr_data (wr_state)
    );

    // evaluation of the stored channel state
    assign sounding = wave_reg >= SOUNDING_MIN;
    assign retrig_c = sounding && wave_reg[GATE_BIT] &&
                      (!prev_state.wave[GATE_BIT] || (prev_state.wave < SOUNDING_MIN));
    assign search_c = (first_reg || retrig_c || (freq_reg != prev_state.freq)) && sounding;
    assign delta_c  = {1'b0, freq_reg} - {1'b0, prev_state.freq};

    // one table entry per scan cycle, strictly nearer wins
    assign idx      = cnt_reg[NOTE_W-1:0];
    assign cmp_freq = note_freq(idx);
    assign diff     = (freq_reg >= cmp_freq) ? (freq_reg - cmp_freq) : (cmp_freq - freq_reg);
    assign win      = {1'b0, diff} < dist_reg;
    assign hit_old  = has_old_reg && (idx == old_note_reg);
    assign cnt_inc  = cnt_reg + 1'b1;
    assign scan_end = (cnt_inc == CNT_W'(NOTE_COUNT));

    // a zero factor acts as one
    assign factor_eff = (factor_reg == '0) ? FACTOR_W'(1) : factor_reg;

    // previous note winning: its distance is divided by the factor before going on
    assign div_req.start    = (state_reg == S_SCAN) && win && hit_old;
    assign div_req.dividend = diff;
    assign div_req.divisor  = factor_eff;

    snt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (in_range_reg && search_c)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_SCAN:
            begin
                if (win && hit_old)
                begin
                    state_next = S_DIV;
                end
                else if (scan_end)
                begin
                    state_next = S_FIN;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = (cnt_reg == CNT_W'(NOTE_COUNT)) ? S_FIN : S_SCAN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            factor_reg    <= FACTOR_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                factor_reg <= cfg_wr_data;
            end
            if ((state_reg == S_FIN) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            ch_reg       <= channel;
            freq_reg     <= osc_freq;
            wave_reg     <= wave_ctrl;
            first_reg    <= first_frame;
            in_range_reg <= int'(channel) < CHANNEL_COUNT;
        end

        if (state_reg == S_EVAL)
        begin
            note_reg     <= prev_state.note;
            old_note_reg <= prev_state.note;
            has_old_reg  <= !retrig_c;
            retrig_reg   <= retrig_c;
            search_reg   <= search_c;
            delta_reg    <= delta_c;
            dist_reg     <= DIST_START;
            cnt_reg      <= '0;
        end

        if (state_reg == S_SCAN)
        begin
            if (win)
            begin
                dist_reg <= {1'b0, diff};
                note_reg <= idx;
            end
            cnt_reg <= cnt_inc;
        end

        if ((state_reg == S_DIV) && div_rsp.done)
        begin
            dist_reg <= {1'b0, div_rsp.quotient};
        end

        if ((state_reg == S_FIN) && out_free)
        begin
            out_channel_reg <= ch_reg;
            if (in_range_reg)
            begin
                out_note_reg    <= note_reg;
                out_changed_reg <= search_reg && (retrig_reg || (note_reg != old_note_reg));
                out_retrig_reg  <= retrig_reg;
                out_delta_reg   <= delta_reg;
                out_search_reg  <= search_reg;
            end
            else
            begin
                // unused channel: echo only the channel number
                out_note_reg    <= '0;
                out_changed_reg <= 1'b0;
                out_retrig_reg  <= 1'b0;
                out_delta_reg   <= '0;
                out_search_reg  <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_channel  = out_channel_reg;
    assign note         = out_note_reg;
    assign note_changed = out_changed_reg;
    assign retrigger    = out_retrig_reg;
    assign freq_delta   = out_delta_reg;
    assign searched     = out_search_reg;

endmodule

// ===== hdl/snt_checker.sv =====
// port-level checks for the note tracker and their binding to the top level
module snt_checker
    import snt_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic [CH_W-1:0]          out_channel,
    input logic [NOTE_W-1:0]        note,
    input logic                     note_changed,
    input logic                     retrigger,
    input logic signed [DIST_W-1:0] freq_delta,
    input logic                     searched
);

    // a held result keeps its note, frequency delta and channel
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(note) && $stable(freq_delta)
            && $stable(out_channel))
        else $error("held result changed");

    // one item at a time: a transfer makes the block busy
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after transfer");

    // unused channel gives an all-zero result
    a_unused_channel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (int'(out_channel) >= CHANNEL_COUNT) |->
            (note == '0) && !note_changed && !retrigger && !searched && (freq_delta == '0))
        else $error("unused channel result not zero");

    // a note change only comes from a search
    a_change_needs_search: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !searched |-> !note_changed)
        else $error("note change without search");

    // a retrigger with a search always reports a new note
    a_retrig_changes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && retrigger && searched |-> note_changed)
        else $error("retrigger search without note change");

endmodule

bind sticky_nearest_note_tracker_top snt_checker u_snt_checker (.*);

// ===== tb/sv/sticky_nearest_note_tracker_top_test.sv =====
// self-checking testbench for the sticky nearest-note tracker top level
`timescale 1ns / 1ps

module sticky_nearest_note_tracker_top_test;
    import snt_pkg::*;

    // a search walks the whole table and may need the divider on top
    localparam int SETTLE_CYCLES = NOTE_COUNT + 40;
    localparam int RANDOM_ITEMS  = 400;

    // equal-tempered pitch table, kept here so a bad table in the design shows up
    localparam logic [FREQ_W-1:0] PITCH_FREQ [96] = '{
        16'h0117, 16'h0127, 16'h0139, 16'h014b, 16'h015f, 16'h0174,
        16'h018a, 16'h01a1, 16'h01ba, 16'h01d4, 16'h01f0, 16'h020e,
        16'h022d, 16'h024e, 16'h0271, 16'h0296, 16'h02be, 16'h02e8,
        16'h0314, 16'h0343, 16'h0374, 16'h03a9, 16'h03e1, 16'h041c,
        16'h045a, 16'h049c, 16'h04e2, 16'h052d, 16'h057c, 16'h05cf,
        16'h0628, 16'h0685, 16'h06e8, 16'h0752, 16'h07c1, 16'h0837,
        16'h08b4, 16'h0939, 16'h09c5, 16'h0a5a, 16'h0af7, 16'h0b9e,
        16'h0c4f, 16'h0d0a, 16'h0dd1, 16'h0ea3, 16'h0f82, 16'h106e,
        16'h1168, 16'h1271, 16'h138a, 16'h14b3, 16'h15ee, 16'h173c,
        16'h189e, 16'h1a15, 16'h1ba2, 16'h1d46, 16'h1f04, 16'h20dc,
        16'h22d0, 16'h24e2, 16'h2714, 16'h2967, 16'h2bdd, 16'h2e79,
        16'h313c, 16'h3429, 16'h3744, 16'h3a8d, 16'h3e08, 16'h41b8,
        16'h45a1, 16'h49c5, 16'h4e28, 16'h52cd, 16'h57ba, 16'h5cf1,
        16'h6278, 16'h6853, 16'h6e87, 16'h751a, 16'h7c10, 16'h8371,
        16'h8b42, 16'h9389, 16'h9c4f, 16'ha59b, 16'haf74, 16'hb9e2,
        16'hc4f0, 16'hd0a6, 16'hdd0e, 16'hea33, 16'hf820, 16'hffff
    };

    // one result as the block should report it
    typedef struct packed {
        logic [CH_W-1:0]   chan;
        logic [NOTE_W-1:0] note;
        logic              changed;
        logic              retrig;
        logic [DIST_W-1:0] delta;
        logic              searched;
    } note_report_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_wr_en;
    logic [FACTOR_W-1:0]      cfg_wr_data;
    logic                     in_valid;
    logic                     in_stall;
    logic [CH_W-1:0]          channel;
    logic [FREQ_W-1:0]        osc_freq;
    logic [WAVE_W-1:0]        wave_ctrl;
    logic                     first_frame;
    logic                     out_valid;
    logic                     out_stall;
    logic [CH_W-1:0]          res_channel;
    logic [NOTE_W-1:0]        res_note;
    logic                     res_changed;
    logic                     res_retrig;
    logic signed [DIST_W-1:0] res_delta;
    logic                     res_searched;

    // predictor copy of the per-channel state and the stickiness register
    logic [NOTE_W-1:0]   track_note [CHANNEL_COUNT];
    logic [FREQ_W-1:0]   track_freq [CHANNEL_COUNT];
    logic [WAVE_W-1:0]   track_wave [CHANNEL_COUNT];
    logic [FACTOR_W-1:0] stickiness;

    // reports waiting for the block, oldest first
    note_report_t expected_reports [$];

    int fail_count;
    int snapshots_sent;
    int reports_checked;
    int searches_seen;
    int retriggers_seen;
    int changes_seen;
    int factor_writes;
    int gap_free_left;

    sticky_nearest_note_tracker_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .channel      (channel),
        .osc_freq     (osc_freq),
        .wave_ctrl    (wave_ctrl),
        .first_frame  (first_frame),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_channel  (res_channel),
        .note         (res_note),
        .note_changed (res_changed),
        .retrigger    (res_retrig),
        .freq_delta   (res_delta),
        .searched     (res_searched)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // generous fixed limit, far above the slowest legal run
    initial
    begin
        #40_000_000;
        $display("%0t ns: timeout with %0d reports still expected", $time,
                 expected_reports.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // nearest-note tracking of one snapshot; updates the predictor state
    function automatic note_report_t track_snapshot(input logic [CH_W-1:0] ch,
                                                    input logic [FREQ_W-1:0] freq,
                                                    input logic [WAVE_W-1:0] wave,
                                                    input logic first);
        note_report_t rep;
        int unsigned best;
        int unsigned diff;
        int unsigned divisor;
        int unsigned entry;
        int d;
        logic sounding;
        logic key_on;
        logic favor_old;
        logic [NOTE_W-1:0] nt;
        logic [NOTE_W-1:0] old_nt;
        rep = '0;
        rep.chan = ch;
        // unused channel: echo only, no state touched
        if (int'(ch) < CHANNEL_COUNT)
        begin
            old_nt   = track_note[ch];
            nt       = old_nt;
            sounding = wave >= SOUNDING_MIN;
            // gate rising, or gate held over from a silent frame
            key_on   = sounding && wave[GATE_BIT] &&
                       (!track_wave[ch][GATE_BIT] || track_wave[ch] < SOUNDING_MIN);
            divisor  = (stickiness == 0) ? 1 : stickiness;
            if (sounding && (first || key_on || freq != track_freq[ch]))
            begin
                best      = 32'h7fff_ffff;
                favor_old = !key_on;
                for (d = 0; d < NOTE_COUNT; d++)
                begin
                    entry = (d < 96) ? PITCH_FREQ[d] : 16'hffff;
                    diff  = (freq >= entry) ? freq - entry : entry - freq;
                    // strictly nearer wins; the old note shrinks the bar at once
                    if (diff < best)
                    begin
                        best = diff;
                        if (favor_old && d == int'(old_nt))
                            best = best / divisor;
                        nt = NOTE_W'(d);
                    end
                end
                rep.searched = 1'b1;
                rep.changed  = key_on || nt != old_nt;
            end
            rep.note    = nt;
            rep.retrig  = key_on;
            rep.delta   = {1'b0, freq} - {1'b0, track_freq[ch]};
            track_note[ch] = nt;
            track_freq[ch] = freq;
            track_wave[ch] = wave;
        end
        return rep;
    endfunction

    // sender gaps: mostly none or short, a few long, with gap-free stretches
    function automatic int pick_gap();
        int r;
        if (gap_free_left > 0)
        begin
            gap_free_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            gap_free_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [FREQ_W-1:0] clamp_freq(input int f);
        if (f < 0)
            return '0;
        if (f > 65535)
            return '1;
        return FREQ_W'(f);
    endfunction

    // a frequency on, between or around a table note
    function automatic int near_note_freq();
        int n;
        int r;
        int spread;
        n = $urandom_range(0, 95);
        r = $urandom_range(0, 9);
        spread = (n < 95) ? int'(PITCH_FREQ[n + 1]) - int'(PITCH_FREQ[n]) : 64;
        if (r < 2)
            return PITCH_FREQ[n];
        if (r < 4 && n < 95)
            return (int'(PITCH_FREQ[n]) + int'(PITCH_FREQ[n + 1])) / 2;
        return int'(PITCH_FREQ[n]) + int'($urandom_range(0, 2 * spread)) - spread;
    endfunction

    // one snapshot transfer; leaves in_valid high for a back-to-back follower
    task automatic send_snapshot(input logic [CH_W-1:0] ch, input logic [FREQ_W-1:0] freq,
                                 input logic [WAVE_W-1:0] wave, input logic first);
        int gap;
        note_report_t rep;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        channel     <= ch;
        osc_freq    <= freq;
        wave_ctrl   <= wave;
        first_frame <= first;
        do
            @(posedge clk);
        while (in_stall);
        // transfer taken at this edge
        rep = track_snapshot(ch, freq, wave, first);
        expected_reports.push_back(rep);
        snapshots_sent++;
        searches_seen   += rep.searched;
        retriggers_seen += rep.retrig;
        changes_seen    += rep.changed;
    endtask

    // register writes only once the block has gone quiet
    task automatic drain_and_set_factor(input logic [FACTOR_W-1:0] value);
        in_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        stickiness  = value;
        factor_writes++;
    endtask

    // gate-on, a few held frames with slide or vibrato, then often a gate-off
    task automatic play_phrase(input logic [CH_W-1:0] ch);
        logic [WAVE_W-1:0] voice;
        int base;
        int frames;
        int slide;
        int wobble;
        int f;
        voice  = {4'($urandom_range(1, 15)), 3'($urandom_range(0, 7)), 1'b0};
        base   = near_note_freq();
        frames = $urandom_range(1, 8);
        slide  = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 400)) - 200 : 0;
        wobble = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        send_snapshot(ch, clamp_freq(base), voice | 8'h01, $urandom_range(0, 19) == 0);
        for (f = 1; f < frames; f++)
        begin
            send_snapshot(ch,
                          clamp_freq(base + f * slide +
                                     int'($urandom_range(0, 2 * wobble)) - wobble),
                          voice | 8'h01, $urandom_range(0, 29) == 0);
        end
        if ($urandom_range(0, 2) != 0)
            send_snapshot(ch, clamp_freq(base + frames * slide), voice, 1'b0);
    endtask

    // silent waveforms: no search, delta still reported
    task automatic test_quiet_channels();
        send_snapshot(2'd0, 16'h0000, 8'h00, 1'b0);
        send_snapshot(2'd0, 16'hffff, 8'h0f, 1'b0);
        send_snapshot(2'd1, 16'h1234, 8'h01, 1'b1);
    endtask

    // key-on detection, held gate, gate drop and rise, first-frame search
    task automatic test_retrigger_rules();
        send_snapshot(2'd1, 16'h1234, 8'h11, 1'b0);
        send_snapshot(2'd1, 16'h1234, 8'h11, 1'b0);
        send_snapshot(2'd1, 16'h1240, 8'h11, 1'b0);
        send_snapshot(2'd1, 16'h1240, 8'h10, 1'b0);
        send_snapshot(2'd1, 16'h1240, 8'h81, 1'b0);
        send_snapshot(2'd1, 16'h1240, 8'h81, 1'b1);
    endtask

    // lowest and highest frequencies, and a tie between two notes
    task automatic test_range_extremes();
        send_snapshot(2'd2, 16'h0000, 8'h21, 1'b0);
        send_snapshot(2'd2, 16'hffff, 8'hf1, 1'b0);
        send_snapshot(2'd0, 16'h8000, 8'h40, 1'b1);
        send_snapshot(2'd0, 16'h011f, 8'h40, 1'b0);
    endtask

    // strongest stickiness holds the old note even against an exact match
    task automatic test_sticky_note();
        drain_and_set_factor(8'd255);
        send_snapshot(2'd0, 16'h0117, 8'h11, 1'b0);
        send_snapshot(2'd0, 16'h0127, 8'h11, 1'b0);
        send_snapshot(2'd0, 16'h0400, 8'h11, 1'b0);
        send_snapshot(2'd0, 16'h0400, 8'h10, 1'b0);
        send_snapshot(2'd0, 16'h0400, 8'h11, 1'b0);
    endtask

    // the fourth channel number has no state behind it
    task automatic test_unused_channel();
        send_snapshot(2'd3, 16'hffff, 8'hff, 1'b1);
        send_snapshot(2'd3, 16'h0000, 8'h00, 1'b0);
    endtask

    // a zero factor behaves as no stickiness
    task automatic test_factor_zero();
        drain_and_set_factor(8'd0);
        send_snapshot(2'd2, 16'h1000, 8'h21, 1'b0);
        send_snapshot(2'd2, 16'h1100, 8'h21, 1'b0);
        send_snapshot(2'd2, 16'h1100, 8'h21, 1'b1);
    endtask

    // mostly musical phrases with random content, the rest raw noise
    task automatic test_random_phase(input logic [FACTOR_W-1:0] factor, input int count);
        int start;
        drain_and_set_factor(factor);
        start = snapshots_sent;
        while (snapshots_sent - start < count)
        begin
            if ($urandom_range(0, 3) != 0)
                play_phrase(CH_W'($urandom_range(0, CHANNEL_COUNT - 1)));
            else
                send_snapshot(CH_W'($urandom_range(0, 3)), FREQ_W'($urandom),
                              WAVE_W'($urandom), 1'($urandom));
        end
    endtask

    // receiver side: stall runs mostly short, a few long, with long open stretches
    initial
    begin
        int open_run;
        int hold_run;
        int r;
        out_stall <= 1'b0;
        forever
        begin
            r        = $urandom_range(0, 99);
            open_run = (r < 10) ? $urandom_range(100, 300) : $urandom_range(0, 8);
            r        = $urandom_range(0, 99);
            hold_run = (r < 70) ? $urandom_range(1, 3) :
                       (r < 95) ? $urandom_range(4, 12) : $urandom_range(20, 60);
            repeat (open_run)
            begin
                @(posedge clk);
                out_stall <= 1'b0;
            end
            repeat (hold_run)
            begin
                @(posedge clk);
                out_stall <= 1'b1;
            end
        end
    end

    task automatic compare_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            fail_count++;
        end
    endtask

    // every result transfer is matched against the oldest expected report
    always @(posedge clk)
    begin
        note_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_reports.size() == 0)
            begin
                $display("%0t ns: unexpected result, channel %0d note %0d", $time,
                         res_channel, res_note);
                fail_count++;
            end
            else
            begin
                want = expected_reports.pop_front();
                compare_field("out_channel", want.chan, res_channel);
                compare_field("note", want.note, res_note);
                compare_field("note_changed", want.changed, res_changed);
                compare_field("retrigger", want.retrig, res_retrig);
                compare_field("freq_delta", int'($signed(want.delta)), int'(res_delta));
                compare_field("searched", want.searched, res_searched);
                reports_checked++;
            end
        end
    end

    initial
    begin
        int i;
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        in_valid    <= 1'b0;
        channel     <= '0;
        osc_freq    <= '0;
        wave_ctrl   <= '0;
        first_frame <= 1'b0;
        fail_count      = 0;
        snapshots_sent  = 0;
        reports_checked = 0;
        searches_seen   = 0;
        retriggers_seen = 0;
        changes_seen    = 0;
        factor_writes   = 0;
        gap_free_left   = 0;
        // reset state of the block: everything zero, factor of one
        stickiness = 8'd1;
        for (i = 0; i < CHANNEL_COUNT; i++)
        begin
            track_note[i] = '0;
            track_freq[i] = '0;
            track_wave[i] = '0;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_quiet_channels();
        test_retrigger_rules();
        test_range_extremes();
        test_sticky_note();
        test_unused_channel();
        test_factor_zero();

        // sweep of stickiness settings, extremes included
        test_random_phase(8'd1, RANDOM_ITEMS);
        test_random_phase(8'd255, RANDOM_ITEMS);
        test_random_phase(8'd2, RANDOM_ITEMS);
        test_random_phase(FACTOR_W'($urandom_range(3, 254)), RANDOM_ITEMS);
        test_random_phase(8'd0, RANDOM_ITEMS);

        // let the last results drain, then watch for strays
        in_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d snapshots and %0d checked results under %0d factor writes",
                 snapshots_sent, reports_checked, factor_writes);
        $display("with %0d note searches, %0d retriggers and %0d note changes",
                 searches_seen, retriggers_seen, changes_seen);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
